@@ design/tmg_pkg.sv @@
package tmg_pkg;

    localparam int VALUE_WIDTH  = 16;
    localparam int DIFF_WIDTH   = VALUE_WIDTH + 1;
    localparam int UMAG_WIDTH   = DIFF_WIDTH + VALUE_WIDTH;
    localparam int MEMB_WIDTH   = 16;
    localparam int SQ_WIDTH     = 31;
    localparam int COMMON_WIDTH = 15;
    localparam int GRAD_WIDTH   = 32;
    localparam int SEG_SHIFT    = 13;
    localparam int SEG_BITS     = 5;
    localparam int RANGE_SHIFT  = SEG_SHIFT + SEG_BITS;
    localparam int INTERP_WIDTH = 25;
    localparam int CFG_INDEX_WIDTH = 2;
    localparam int IN_DATA_WIDTH   = 16;
    localparam int OUT_DATA_WIDTH  = MEMB_WIDTH + 2 * GRAD_WIDTH;

    localparam logic [VALUE_WIDTH-1:0] CROSSPOINT_RESET = 16'h0000;
    localparam logic [VALUE_WIDTH-1:0] SLOPE_RESET      = 16'h0100;
    localparam logic [MEMB_WIDTH-1:0]  ONE_Q15          = 16'd32768;
    localparam logic [MEMB_WIDTH:0]    HALF_ROUND       = 17'd32769;
    localparam logic [31:0]            COMMON_BIAS      = 32'h4000_8000;
    localparam logic [INTERP_WIDTH-1:0] INTERP_ROUND    = 25'd4096;
    localparam logic [32:0]            GRAD_ROUND       = 33'd128;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        REG_CROSSPOINT = 2'd0,
        REG_SLOPE      = 2'd1
    } cfg_reg_t;

    typedef struct packed {
        logic [UMAG_WIDTH-1:0]  u_mag;
        logic [DIFF_WIDTH-1:0]  d_mag;
        logic [VALUE_WIDTH-1:0] s_mag;
        logic                   u_neg;
        logic                   d_neg;
        logic                   s_pos;
    } front_t;

    typedef struct packed {
        logic [MEMB_WIDTH-1:0]  memb;
        logic [SQ_WIDTH-1:0]    sq;
        logic [DIFF_WIDTH-1:0]  d_mag;
        logic [VALUE_WIDTH-1:0] s_mag;
        logic                   d_neg;
        logic                   s_pos;
    } tanh_t;

    function automatic logic [MEMB_WIDTH-1:0] tanh_base(input logic [SEG_BITS:0] idx);
        logic [MEMB_WIDTH-1:0] v;
        unique case (idx)
            6'd0:    v = 16'd0;
            6'd1:    v = 16'd4075;
            6'd2:    v = 16'd8026;
            6'd3:    v = 16'd11743;
            6'd4:    v = 16'd15143;
            6'd5:    v = 16'd18173;
            6'd6:    v = 16'd20813;
            6'd7:    v = 16'd23066;
            6'd8:    v = 16'd24956;
            6'd9:    v = 16'd26519;
            6'd10:   v = 16'd27797;
            6'd11:   v = 16'd28830;
            6'd12:   v = 16'd29660;
            6'd13:   v = 16'd30322;
            6'd14:   v = 16'd30847;
            6'd15:   v = 16'd31262;
            6'd16:   v = 16'd31589;
            6'd17:   v = 16'd31846;
            6'd18:   v = 16'd32048;
            6'd19:   v = 16'd32206;
            6'd20:   v = 16'd32329;
            6'd21:   v = 16'd32426;
            6'd22:   v = 16'd32501;
            6'd23:   v = 16'd32560;
            6'd24:   v = 16'd32606;
            6'd25:   v = 16'd32642;
            6'd26:   v = 16'd32670;
            6'd27:   v = 16'd32691;
            6'd28:   v = 16'd32708;
            6'd29:   v = 16'd32721;
            6'd30:   v = 16'd32732;
            6'd31:   v = 16'd32740;
            default: v = 16'd32746;
        endcase
        return v;
    endfunction

endpackage

@@ design/tmg_front.sv @@
module tmg_front (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [tmg_pkg::VALUE_WIDTH-1:0] sample,
    input  logic signed [tmg_pkg::VALUE_WIDTH-1:0] crosspoint,
    input  logic signed [tmg_pkg::VALUE_WIDTH-1:0] slope,
    output logic                                out_valid,
    input  logic                                out_ready,
    output tmg_pkg::front_t                     out_data
);
    import tmg_pkg::*;

    logic                   s1_vld_reg;
    logic [DIFF_WIDTH-1:0]  s1_d_mag_reg;
    logic [DIFF_WIDTH-1:0]  s1_d_mag_next;
    logic [VALUE_WIDTH-1:0] s1_s_mag_reg;
    logic [VALUE_WIDTH-1:0] s1_s_mag_next;
    logic                   s1_d_neg_reg;
    logic                   s1_d_neg_next;
    logic                   s1_s_neg_reg;
    logic                   s1_s_neg_next;
    logic                   s1_s_pos_reg;
    logic                   s1_s_pos_next;
    logic [DIFF_WIDTH-1:0]  diff;
    logic [VALUE_WIDTH-1:0] slope_bits;
    logic                   s1_ready;

    logic                   s2_vld_reg;
    front_t                 s2_data_reg;
    front_t                 s2_data_next;
    logic                   s2_ready;

    assign s2_ready = !s2_vld_reg || out_ready;
    assign s1_ready = !s1_vld_reg || s2_ready;
    assign in_ready = s1_ready;

    always_comb
    begin
        diff          = {sample[VALUE_WIDTH-1], sample} - {crosspoint[VALUE_WIDTH-1], crosspoint};
        slope_bits    = slope;
        s1_d_neg_next = diff[DIFF_WIDTH-1];
        s1_d_mag_next = s1_d_neg_next ? (~diff + 17'd1) : diff;
        s1_s_neg_next = slope_bits[VALUE_WIDTH-1];
        s1_s_mag_next = s1_s_neg_next ? (~slope_bits + 16'd1) : slope_bits;
        s1_s_pos_next = !s1_s_neg_next && (slope_bits != '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
        end
        else if (s1_ready)
        begin
            s1_vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready && in_valid)
        begin
            s1_d_mag_reg <= s1_d_mag_next;
            s1_s_mag_reg <= s1_s_mag_next;
            s1_d_neg_reg <= s1_d_neg_next;
            s1_s_neg_reg <= s1_s_neg_next;
            s1_s_pos_reg <= s1_s_pos_next;
        end
    end

    always_comb
    begin
        s2_data_next.u_mag = UMAG_WIDTH'(s1_d_mag_reg) * UMAG_WIDTH'(s1_s_mag_reg);
        s2_data_next.d_mag = s1_d_mag_reg;
        s2_data_next.s_mag = s1_s_mag_reg;
        s2_data_next.u_neg = s1_d_neg_reg ^ s1_s_neg_reg;
        s2_data_next.d_neg = s1_d_neg_reg;
        s2_data_next.s_pos = s1_s_pos_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_vld_reg <= 1'b0;
        end
        else if (s2_ready)
        begin
            s2_vld_reg <= s1_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_ready && s1_vld_reg)
        begin
            s2_data_reg <= s2_data_next;
        end
    end

    assign out_valid = s2_vld_reg;
    assign out_data  = s2_data_reg;

endmodule

@@ design/tmg_tanh.sv @@
module tmg_tanh (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  tmg_pkg::front_t in_data,
    output logic            out_valid,
    input  logic            out_ready,
    output tmg_pkg::tanh_t  out_data
);
    import tmg_pkg::*;

    logic                    s3_vld_reg;
    logic [MEMB_WIDTH-1:0]   s3_tm_reg;
    logic [MEMB_WIDTH-1:0]   s3_tm_next;
    logic [DIFF_WIDTH-1:0]   s3_d_mag_reg;
    logic [VALUE_WIDTH-1:0]  s3_s_mag_reg;
    logic                    s3_u_neg_reg;
    logic                    s3_d_neg_reg;
    logic                    s3_s_pos_reg;
    logic                    s3_ready;

    logic                    beyond;
    logic [SEG_BITS:0]       seg;
    logic [SEG_SHIFT-1:0]    offset;
    logic [MEMB_WIDTH-1:0]   v0;
    logic [MEMB_WIDTH-1:0]   v1;
    logic [MEMB_WIDTH-1:0]   step_full;
    logic [11:0]             step;
    logic [INTERP_WIDTH-1:0] interp;

    logic                    s4_vld_reg;
    tanh_t                   s4_data_reg;
    tanh_t                   s4_data_next;
    logic                    s4_ready;
    logic [MEMB_WIDTH:0]     half_sum;
    logic [31:0]             sq_full;

    assign s4_ready = !s4_vld_reg || out_ready;
    assign s3_ready = !s3_vld_reg || s4_ready;
    assign in_ready = s3_ready;

    always_comb
    begin
        beyond     = |in_data.u_mag[UMAG_WIDTH-1:RANGE_SHIFT];
        seg        = {1'b0, in_data.u_mag[RANGE_SHIFT-1:SEG_SHIFT]};
        offset     = in_data.u_mag[SEG_SHIFT-1:0];
        v0         = tanh_base(seg);
        v1         = tanh_base(seg + 6'd1);
        step_full  = v1 - v0;
        step       = step_full[11:0];
        interp     = INTERP_WIDTH'(step) * INTERP_WIDTH'(offset) + INTERP_ROUND;
        s3_tm_next = beyond ? ONE_Q15
                            : v0 + MEMB_WIDTH'(interp[INTERP_WIDTH-1:SEG_SHIFT]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_vld_reg <= 1'b0;
        end
        else if (s3_ready)
        begin
            s3_vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s3_ready && in_valid)
        begin
            s3_tm_reg    <= s3_tm_next;
            s3_d_mag_reg <= in_data.d_mag;
            s3_s_mag_reg <= in_data.s_mag;
            s3_u_neg_reg <= in_data.u_neg;
            s3_d_neg_reg <= in_data.d_neg;
            s3_s_pos_reg <= in_data.s_pos;
        end
    end

    always_comb
    begin
        half_sum = s3_u_neg_reg ? (HALF_ROUND - 17'(s3_tm_reg))
                                : (HALF_ROUND + 17'(s3_tm_reg));
        sq_full  = 32'(s3_tm_reg) * 32'(s3_tm_reg);
        s4_data_next.memb  = half_sum[MEMB_WIDTH:1];
        s4_data_next.sq    = sq_full[SQ_WIDTH-1:0];
        s4_data_next.d_mag = s3_d_mag_reg;
        s4_data_next.s_mag = s3_s_mag_reg;
        s4_data_next.d_neg = s3_d_neg_reg;
        s4_data_next.s_pos = s3_s_pos_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_vld_reg <= 1'b0;
        end
        else if (s4_ready)
        begin
            s4_vld_reg <= s3_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s4_ready && s3_vld_reg)
        begin
            s4_data_reg <= s4_data_next;
        end
    end

    assign out_valid = s4_vld_reg;
    assign out_data  = s4_data_reg;

endmodule

@@ design/tmg_grad.sv @@
module tmg_grad (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  tmg_pkg::tanh_t                     in_data,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [tmg_pkg::MEMB_WIDTH-1:0]     membership,
    output logic signed [tmg_pkg::GRAD_WIDTH-1:0] grad_cross,
    output logic signed [tmg_pkg::GRAD_WIDTH-1:0] grad_slope
);
    import tmg_pkg::*;

    logic                    s5_vld_reg;
    logic [COMMON_WIDTH-1:0] s5_common_reg;
    logic [COMMON_WIDTH-1:0] s5_common_next;
    logic [MEMB_WIDTH-1:0]   s5_memb_reg;
    logic [DIFF_WIDTH-1:0]   s5_d_mag_reg;
    logic [VALUE_WIDTH-1:0]  s5_s_mag_reg;
    logic                    s5_d_neg_reg;
    logic                    s5_s_pos_reg;
    logic                    s5_ready;
    logic [31:0]             common_full;

    logic                    s6_vld_reg;
    logic [30:0]             s6_pc_reg;
    logic [30:0]             s6_pc_next;
    logic [31:0]             s6_ps_reg;
    logic [31:0]             s6_ps_next;
    logic [MEMB_WIDTH-1:0]   s6_memb_reg;
    logic                    s6_d_neg_reg;
    logic                    s6_s_pos_reg;
    logic                    s6_ready;

    logic                    s7_vld_reg;
    logic [MEMB_WIDTH-1:0]   s7_memb_reg;
    logic [GRAD_WIDTH-1:0]   s7_gc_reg;
    logic [GRAD_WIDTH-1:0]   s7_gc_next;
    logic [GRAD_WIDTH-1:0]   s7_gs_reg;
    logic [GRAD_WIDTH-1:0]   s7_gs_next;
    logic                    s7_ready;
    logic [32:0]             gc_round;
    logic [32:0]             gs_round;
    logic [GRAD_WIDTH-1:0]   gc_mag;
    logic [GRAD_WIDTH-1:0]   gs_mag;

    assign s7_ready = !s7_vld_reg || out_ready;
    assign s6_ready = !s6_vld_reg || s7_ready;
    assign s5_ready = !s5_vld_reg || s6_ready;
    assign in_ready = s5_ready;

    always_comb
    begin
        common_full    = COMMON_BIAS - 32'(in_data.sq);
        s5_common_next = common_full[30:16];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s5_vld_reg <= 1'b0;
        end
        else if (s5_ready)
        begin
            s5_vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s5_ready && in_valid)
        begin
            s5_common_reg <= s5_common_next;
            s5_memb_reg   <= in_data.memb;
            s5_d_mag_reg  <= in_data.d_mag;
            s5_s_mag_reg  <= in_data.s_mag;
            s5_d_neg_reg  <= in_data.d_neg;
            s5_s_pos_reg  <= in_data.s_pos;
        end
    end

    always_comb
    begin
        s6_pc_next = 31'(s5_common_reg) * 31'(s5_s_mag_reg);
        s6_ps_next = 32'(s5_common_reg) * 32'(s5_d_mag_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s6_vld_reg <= 1'b0;
        end
        else if (s6_ready)
        begin
            s6_vld_reg <= s5_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s6_ready && s5_vld_reg)
        begin
            s6_pc_reg    <= s6_pc_next;
            s6_ps_reg    <= s6_ps_next;
            s6_memb_reg  <= s5_memb_reg;
            s6_d_neg_reg <= s5_d_neg_reg;
            s6_s_pos_reg <= s5_s_pos_reg;
        end
    end

    // Both magnitudes stay well below 2^31, so the sign can be applied without clipping.
    always_comb
    begin
        gc_round   = 33'(s6_pc_reg) + GRAD_ROUND;
        gs_round   = 33'(s6_ps_reg) + GRAD_ROUND;
        gc_mag     = GRAD_WIDTH'(gc_round[32:8]);
        gs_mag     = GRAD_WIDTH'(gs_round[32:8]);
        s7_gc_next = s6_s_pos_reg ? (~gc_mag + 32'd1) : gc_mag;
        s7_gs_next = s6_d_neg_reg ? (~gs_mag + 32'd1) : gs_mag;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s7_vld_reg <= 1'b0;
        end
        else if (s7_ready)
        begin
            s7_vld_reg <= s6_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s7_ready && s6_vld_reg)
        begin
            s7_memb_reg <= s6_memb_reg;
            s7_gc_reg   <= s7_gc_next;
            s7_gs_reg   <= s7_gs_next;
        end
    end

    assign out_valid  = s7_vld_reg;
    assign membership = s7_memb_reg;
    assign grad_cross = s7_gc_reg;
    assign grad_slope = s7_gs_reg;

    a_common_range: assert property (@(posedge clk) disable iff (!rst_n)
        s5_vld_reg |-> (s5_common_reg <= 15'd16384))
        else $error("common factor above one half");

    a_memb_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (membership <= ONE_Q15))
        else $error("membership above one");

    a_rail_flat: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (membership == '0 || membership == ONE_Q15))
        |-> (grad_cross == '0 && grad_slope == '0))
        else $error("gradient not zero at a saturated membership");

endmodule

@@ design/tanh_membership_with_gradient.sv @@
// Channel  Direction  Payload
// s_axis   in         tdata[15:0] sample
// m_axis   out        tdata[15:0] membership, [47:16] grad_cross, [79:48] grad_slope
// cfg      in         cfg_index 0 crosspoint, 1 slope; other indexes are ignored
//
// One item is taken per cycle while s_axis_tready is high; a stall at m_axis can hold it low.
// Each item passes through seven register stages: difference, product, table
// interpolation, square, common factor, gradient products and the output register.
// Reset clears the stage valid bits and loads crosspoint 0 and slope 1.0.
// A stall at m_axis holds every stage whose successor is full; no item is lost.
module tanh_membership_with_gradient (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [tmg_pkg::IN_DATA_WIDTH-1:0]    s_axis_tdata,   // sample
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [tmg_pkg::OUT_DATA_WIDTH-1:0]   m_axis_tdata,   // membership, grad_cross, grad_slope
    input  logic                                 cfg_we,
    input  logic [tmg_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
    input  logic [tmg_pkg::VALUE_WIDTH-1:0]      cfg_data
);
    import tmg_pkg::*;

    logic signed [VALUE_WIDTH-1:0] crosspoint_reg;
    logic signed [VALUE_WIDTH-1:0] slope_reg;
    logic signed [VALUE_WIDTH-1:0] sample;

    logic                          front_valid;
    logic                          front_ready;
    front_t                        front_data;
    logic                          tanh_valid;
    logic                          tanh_ready;
    tanh_t                         tanh_data;
    logic [MEMB_WIDTH-1:0]         membership;
    logic signed [GRAD_WIDTH-1:0]  grad_cross;
    logic signed [GRAD_WIDTH-1:0]  grad_slope;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crosspoint_reg <= CROSSPOINT_RESET;
            slope_reg      <= SLOPE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_CROSSPOINT: crosspoint_reg <= cfg_data;
                REG_SLOPE:      slope_reg      <= cfg_data;
                default:        ;
            endcase
        end
    end

    assign sample = s_axis_tdata;

    tmg_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .sample     (sample),
        .crosspoint (crosspoint_reg),
        .slope      (slope_reg),
        .out_valid  (front_valid),
        .out_ready  (front_ready),
        .out_data   (front_data)
    );

    tmg_tanh u_tanh (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .in_data   (front_data),
        .out_valid (tanh_valid),
        .out_ready (tanh_ready),
        .out_data  (tanh_data)
    );

    tmg_grad u_grad (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (tanh_valid),
        .in_ready   (tanh_ready),
        .in_data    (tanh_data),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .membership (membership),
        .grad_cross (grad_cross),
        .grad_slope (grad_slope)
    );

    assign m_axis_tdata = {grad_slope, grad_cross, membership};

endmodule
